>>> rtl/mhpq_pkg.sv
// Shared types for the binary max-heap priority queue.
// Holds operation and status codes and the controller/datapath command and status structs.
// Has no dependencies.
`timescale 1ns / 1ps

package mhpq_pkg;

  // Operation codes carried in the input word.
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_PEEK   = 2'd2
  } op_e;

  // Status codes returned in the result word.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    accept;     // input word taken this cycle
    status_e code;       // status to record on accept
    logic    start_ins;  // begin an insert
    logic    start_rm;   // begin a remove, read root and last entry
    logic    up_rd;      // sift up: read parent or settle at root
    logic    up_cmp;     // sift up: compare with parent and write
    logic    rm_ld;      // remove: capture root and last entry
    logic    pk_ld;      // peek: capture root
    logic    dn_rd;      // sift down: read children or settle at leaf
    logic    dn_cmp;     // sift down: compare with larger child and write
    logic    load_out;   // copy result into the output register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;       // no entries held
    logic full;        // all entries in use
    logic at_root;     // moving entry sits at the root
    logic up_greater;  // moving key beats its parent
    logic dn_leaf;     // moving entry has no children
    logic dn_greater;  // larger child beats the moving key
  } dp_stat_t;

endpackage

>>> rtl/mhpq_ram.sv
// Generic RAM with one write port and two registered read ports.
// Used for the heap store; depends on nothing.
`timescale 1ns / 1ps

module mhpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered reads.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

>>> rtl/mhpq_ctrl.sv
// Controller state machine for the max-heap priority queue.
// Sequences insert, remove and peek steps; depends on mhpq_pkg.
`timescale 1ns / 1ps

module mhpq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        op_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  mhpq_pkg::dp_stat_t stat_i,
  output mhpq_pkg::dp_cmd_t  cmd_o
);
  import mhpq_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_UP_RD  = 3'd1;
  localparam logic [2:0] S_UP_CMP = 3'd2;
  localparam logic [2:0] S_RM_LD  = 3'd3;
  localparam logic [2:0] S_PK_LD  = 3'd4;
  localparam logic [2:0] S_DN_RD  = 3'd5;
  localparam logic [2:0] S_DN_CMP = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // Next state and commands.
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    cmd_o.code  = ST_OK;
    out_valid_d = out_valid_q & ~out_ready_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_DONE;
          case (op_i)
            OP_INSERT: begin
              if (stat_i.full) begin
                cmd_o.code = ST_FULL;
              end else begin
                cmd_o.start_ins = 1'b1;
                state_d         = S_UP_RD;
              end
            end
            OP_REMOVE: begin
              if (stat_i.empty) begin
                cmd_o.code = ST_EMPTY;
              end else begin
                cmd_o.start_rm = 1'b1;
                state_d        = S_RM_LD;
              end
            end
            OP_PEEK: begin
              if (stat_i.empty) begin
                cmd_o.code = ST_EMPTY;
              end else begin
                state_d = S_PK_LD;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_UP_RD: begin
        cmd_o.up_rd = 1'b1;
        state_d     = stat_i.at_root ? S_DONE : S_UP_CMP;
      end
      S_UP_CMP: begin
        cmd_o.up_cmp = 1'b1;
        state_d      = stat_i.up_greater ? S_UP_RD : S_DONE;
      end
      S_RM_LD: begin
        cmd_o.rm_ld = 1'b1;
        state_d     = S_DN_RD;
      end
      S_PK_LD: begin
        cmd_o.pk_ld = 1'b1;
        state_d     = S_DONE;
      end
      S_DN_RD: begin
        cmd_o.dn_rd = 1'b1;
        state_d     = stat_i.dn_leaf ? S_DONE : S_DN_CMP;
      end
      S_DN_CMP: begin
        cmd_o.dn_cmp = 1'b1;
        state_d      = stat_i.dn_greater ? S_DN_RD : S_DONE;
      end
      S_DONE: begin
        // Hand the result over once the output register is free.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and output valid registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> rtl/mhpq_dp.sv
// Datapath for the max-heap priority queue: fill count, sift position, moving key,
// result and output registers, and the heap store. Depends on mhpq_pkg and mhpq_ram.
`timescale 1ns / 1ps

module mhpq_dp #(
  parameter int CAPACITY  = 64,
  parameter int KEY_WIDTH = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  mhpq_pkg::dp_cmd_t               cmd_i,
  output mhpq_pkg::dp_stat_t              stat_o,
  input  logic signed [KEY_WIDTH-1:0]     key_i,
  output logic [1:0]                      status_o,
  output logic signed [KEY_WIDTH-1:0]     top_key_o,
  output logic [$clog2(CAPACITY+1)-1:0]   entry_count_o
);
  import mhpq_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]               count_q, count_d;
  logic [AW-1:0]               pos_q, pos_d;
  logic signed [KEY_WIDTH-1:0] key_q, key_d;
  logic signed [KEY_WIDTH-1:0] top_q, top_d;
  status_e                     status_q, status_d;
  logic [1:0]                  out_status_q;
  logic signed [KEY_WIDTH-1:0] out_top_q;
  logic [CW-1:0]               out_count_q;

  logic                        we;
  logic [AW-1:0]               waddr, raddr_a, raddr_b;
  logic [KEY_WIDTH-1:0]        wdata, rdata_a, rdata_b;
  logic signed [KEY_WIDTH-1:0] rd_a, rd_b, pick_val;

  logic [AW-1:0]               parent;
  logic [AW+1:0]               left, right, count_ext;
  logic [CW-1:0]               last;
  logic                        right_ok, take_right;
  logic [AW-1:0]               pick;

  mhpq_ram #(
    .WIDTH (KEY_WIDTH),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  assign rd_a = $signed(rdata_a);
  assign rd_b = $signed(rdata_b);

  // Tree index arithmetic around the moving entry.
  assign parent    = (pos_q - 1'b1) >> 1;
  assign left      = {1'b0, pos_q, 1'b1};
  assign right     = left + 1'b1;
  assign count_ext = (AW + 2)'(count_q);
  assign last      = count_q - 1'b1;

  // Larger child: right only when present and strictly greater.
  assign right_ok   = (right < count_ext);
  assign take_right = right_ok && (rd_b > rd_a);
  assign pick_val   = take_right ? rd_b : rd_a;
  assign pick       = take_right ? right[AW-1:0] : left[AW-1:0];

  assign stat_o.empty      = (count_q == '0);
  assign stat_o.full       = (count_q == CW'(CAPACITY));
  assign stat_o.at_root    = (pos_q == '0);
  assign stat_o.up_greater = (key_q > rd_a);
  assign stat_o.dn_leaf    = (left >= count_ext);
  assign stat_o.dn_greater = (pick_val > key_q);

  // Store port control.
  always_comb begin
    we      = 1'b0;
    waddr   = pos_q;
    wdata   = key_q;
    raddr_a = '0;
    raddr_b = last[AW-1:0];
    if (cmd_i.up_rd) begin
      we      = stat_o.at_root;
      raddr_a = parent;
    end
    if (cmd_i.up_cmp) begin
      we    = 1'b1;
      wdata = stat_o.up_greater ? rd_a : key_q;
    end
    if (cmd_i.dn_rd) begin
      we      = stat_o.dn_leaf;
      raddr_a = left[AW-1:0];
      raddr_b = right[AW-1:0];
    end
    if (cmd_i.dn_cmp) begin
      we    = 1'b1;
      wdata = stat_o.dn_greater ? pick_val : key_q;
    end
  end

  // Working register updates.
  always_comb begin
    count_d  = count_q;
    pos_d    = pos_q;
    key_d    = key_q;
    top_d    = top_q;
    status_d = status_q;
    if (cmd_i.accept) begin
      status_d = cmd_i.code;
      top_d    = '0;
    end
    if (cmd_i.start_ins) begin
      pos_d   = count_q[AW-1:0];
      key_d   = key_i;
      count_d = count_q + 1'b1;
    end
    if (cmd_i.start_rm) begin
      count_d = last;
    end
    if (cmd_i.rm_ld) begin
      top_d = rd_a;
      key_d = rd_b;
      pos_d = '0;
    end
    if (cmd_i.pk_ld) begin
      top_d = rd_a;
    end
    if (cmd_i.up_cmp && stat_o.up_greater) begin
      pos_d = parent;
    end
    if (cmd_i.dn_cmp && stat_o.dn_greater) begin
      pos_d = pick;
    end
  end

  // Fill count is control state and is cleared by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Payload registers, including the output word.
  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    key_q    <= key_d;
    top_q    <= top_d;
    status_q <= status_d;
    if (cmd_i.load_out) begin
      out_status_q <= status_q;
      out_top_q    <= top_q;
      out_count_q  <= count_q;
    end
  end

  assign status_o      = out_status_q;
  assign top_key_o     = out_top_q;
  assign entry_count_o = out_count_q;

endmodule

>>> rtl/max_heap_priority_queue_top.sv
// Top level of the max-heap priority queue.
// Joins the controller (mhpq_ctrl) and the datapath (mhpq_dp); depends on mhpq_pkg.
//
// Usage: one word on the input stream is one operation: insert a key, remove the maximum
// or peek at the maximum. Every accepted word yields exactly one result word carrying a
// status, the key returned by a successful remove or peek (zero otherwise) and the number
// of entries held afterwards. An unused operation code leaves the heap untouched.
// From acceptance to the result register, a refused operation or an unused code goes
// straight to the done state and a peek captures the root first; an insert repeats a
// parent read and a compare-and-write per level climbed, and a remove captures the root
// and last entry, then repeats a child read and a compare-and-write per level descended.
// With the default capacity of 64 an insert climbs at most 6 levels and a remove descends
// at most 5. Insert and remove steps read, compare and write the single heap store.
// One item is worked on at a time; the input is ready whenever the engine is idle, also
// while the previous result still waits in the output register. If the receiver stalls,
// the result holds and the engine waits after its next item until the register frees.
// Reset empties the heap at once; the store contents need no clearing.
`timescale 1ns / 1ps

module max_heap_priority_queue_top #(
  parameter int CAPACITY  = 64,
  parameter int KEY_WIDTH = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  // Input word fields from bit 0: operation (2), key (KEY_WIDTH), zero padding.
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  logic [((2+KEY_WIDTH+7)/8)*8-1:0]       s_axis_tdata,
  // Result word fields from bit 0: status (2), top_key (KEY_WIDTH),
  // entry_count (clog2(CAPACITY+1)), zero padding.
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  output logic [((2+KEY_WIDTH+$clog2(CAPACITY+1)+7)/8)*8-1:0] m_axis_tdata
);
  import mhpq_pkg::*;

  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int OUT_F = 2 + KEY_WIDTH + CW;
  localparam int OUT_W = ((OUT_F + 7) / 8) * 8;

  dp_cmd_t                     cmd;
  dp_stat_t                    stat;
  logic [1:0]                  status;
  logic signed [KEY_WIDTH-1:0] top_key;
  logic [CW-1:0]               entry_count;

  mhpq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .op_i        (s_axis_tdata[1:0]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  mhpq_dp #(
    .CAPACITY  (CAPACITY),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .key_i         ($signed(s_axis_tdata[KEY_WIDTH+1:2])),
    .status_o      (status),
    .top_key_o     (top_key),
    .entry_count_o (entry_count)
  );

  // Pack the result word, padded with zeros.
  assign m_axis_tdata = OUT_W'({entry_count, top_key, status});

endmodule
